/* rtl/websocket_client_frame_encoder_macros.svh */
// Assertion helpers for the frame encoder.
`ifndef WEBSOCKET_CLIENT_FRAME_ENCODER_MACROS_SVH
`define WEBSOCKET_CLIENT_FRAME_ENCODER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define WSENC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition leads to a consequence on the next edge.
`define WSENC_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/wsenc_pkg.sv */
`default_nettype none

package wsenc_pkg;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_DATA  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      FORM_LEN7  = 2'd0,
      FORM_LEN16 = 2'd1,
      FORM_LEN64 = 2'd2
   } len_form_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
   } rsp_beat_type;

   localparam int unsigned HDR_IDX_W = 4;

   localparam logic [7:0]  FIN_BIT    = 8'h80;
   localparam logic [7:0]  MASK_BIT   = 8'h80;
   localparam logic [3:0]  OPCODE_MSK = 4'hF;
   localparam logic [31:0] LEN_MAX7   = 32'd125;
   localparam logic [31:0] LEN_MAX16  = 32'hFFFF;
   localparam logic [6:0]  LEN_MARK16 = 7'd126;
   localparam logic [6:0]  LEN_MARK64 = 7'd127;

   localparam logic [HDR_IDX_W-1:0] KEY_BASE_LEN7  = 4'd2;
   localparam logic [HDR_IDX_W-1:0] KEY_BASE_LEN16 = 4'd4;
   localparam logic [HDR_IDX_W-1:0] KEY_BASE_LEN64 = 4'd10;

   function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] pos);
      logic [7:0] b;
      case (pos)
         2'd0:    b = key[31:24];
         2'd1:    b = key[23:16];
         2'd2:    b = key[15:8];
         default: b = key[7:0];
      endcase
      return b;
   endfunction

   function automatic logic [HDR_IDX_W-1:0] key_base(input len_form_type form);
      logic [HDR_IDX_W-1:0] kb;
      case (form)
         FORM_LEN7:  kb = KEY_BASE_LEN7;
         FORM_LEN16: kb = KEY_BASE_LEN16;
         default:    kb = KEY_BASE_LEN64;
      endcase
      return kb;
   endfunction

   function automatic logic [HDR_IDX_W-1:0] hdr_last(input len_form_type form);
      return key_base(form) + HDR_IDX_W'(3);
   endfunction

   function automatic len_form_type classify(input logic [31:0] len);
      len_form_type f;
      if (len <= LEN_MAX7) begin
         f = FORM_LEN7;
      end else if (len <= LEN_MAX16) begin
         f = FORM_LEN16;
      end else begin
         f = FORM_LEN64;
      end
      return f;
   endfunction

   // header byte at position idx, from the second byte on
   function automatic logic [7:0] hdr_byte(input len_form_type form,
                                           input logic [HDR_IDX_W-1:0] idx,
                                           input logic [31:0] len,
                                           input logic [31:0] key);
      logic [HDR_IDX_W-1:0] kb;
      logic [HDR_IDX_W-1:0] koff;
      logic [7:0]           b;
      kb   = key_base(form);
      koff = idx - kb;
      b    = 8'h00;
      if (idx >= kb) begin
         b = key_byte(key, koff[1:0]);
      end else begin
         case (form)
            FORM_LEN7: begin
               b = MASK_BIT | {1'b0, len[6:0]};
            end
            FORM_LEN16: begin
               case (idx)
                  4'd1:    b = MASK_BIT | {1'b0, LEN_MARK16};
                  4'd2:    b = len[15:8];
                  default: b = len[7:0];
               endcase
            end
            default: begin
               case (idx)
                  4'd1:    b = MASK_BIT | {1'b0, LEN_MARK64};
                  4'd6:    b = len[31:24];
                  4'd7:    b = len[23:16];
                  4'd8:    b = len[15:8];
                  4'd9:    b = len[7:0];
                  default: b = 8'h00;
               endcase
            end
         endcase
      end
      return b;
   endfunction

endpackage

`default_nettype wire

/* rtl/wsenc_rsp_skid.sv */
`default_nettype none

module wsenc_rsp_skid (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  beat_valid,
   input  wire wsenc_pkg::rsp_beat_type beat,
   output logic                       beat_room,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output wsenc_pkg::rsp_beat_type    rsp_beat
);

   logic                    out_valid_ff, out_valid_in;
   wsenc_pkg::rsp_beat_type out_beat_ff, out_beat_in;
   logic                    skid_valid_ff, skid_valid_in;
   wsenc_pkg::rsp_beat_type skid_beat_ff, skid_beat_in;
   logic                    out_free;

   assign beat_room  = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_beat   = out_beat_ff;
   assign out_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_beat_in   = out_beat_ff;
      skid_valid_in = skid_valid_ff;
      skid_beat_in  = skid_beat_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_beat_in   = skid_beat_ff;
            skid_valid_in = 1'b0;
         end else if (beat_valid) begin
            out_valid_in = 1'b1;
            out_beat_in  = beat;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (beat_valid) begin
         skid_valid_in = 1'b1;
         skid_beat_in  = beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_beat_ff  <= out_beat_in;
      skid_beat_ff <= skid_beat_in;
   end

`include "websocket_client_frame_encoder_macros.svh"

   `WSENC_ASSERT(a_skid_behind_out, !skid_valid_ff || out_valid_ff, "skid full with empty output")
   `WSENC_ASSERT_NEXT(a_skid_drains, skid_valid_ff && rsp_tready, !skid_valid_ff, "skid not drained")
   `WSENC_ASSERT_NEXT(a_stall_keeps, out_valid_ff && !rsp_tready, out_valid_ff, "response lost")

endmodule

`default_nettype wire

/* rtl/websocket_client_frame_encoder.sv */
`default_nettype none

// Masked client WebSocket frame encoder. A start request (tuser 0) emits the
// frame header one byte per cycle while the output buffer has room: 6 bytes
// for lengths up to 125, 8 bytes up to 65535, 14 bytes above, ending with
// the four masking key bytes; req_tready stays low while the header after its
// first byte goes out, so a start holds the input until the header is done.
// A payload request (tuser 1) yields one masked byte; rsp_tlast marks the
// last byte of the frame, or the last key byte of an empty frame. Payload
// requests outside a frame are dropped, and a start abandons an open frame.
// A two-entry output buffer decouples req_tready from rsp_tready.

module websocket_client_frame_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // frame_opcode[3:0], payload_length[35:4], masking_key[67:36],
   // data_byte[75:68], zero[79:76]
   input  wire logic [79:0] req_tdata,
   // kind[0]
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_byte[7:0]
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);

   logic [3:0]  req_opcode;
   logic [31:0] req_length;
   logic [31:0] req_key;
   logic [7:0]  req_data;
   logic        req_fire;
   logic        pay_fire;

   logic                                 hdr_active_ff, hdr_active_in;
   logic [wsenc_pkg::HDR_IDX_W-1:0]      hdr_idx_ff, hdr_idx_in;
   logic [wsenc_pkg::HDR_IDX_W-1:0]      hdr_last_idx;
   wsenc_pkg::len_form_type              form_ff, form_in;
   logic [31:0]                          bytes_left_ff, bytes_left_in;
   logic [1:0]                           mask_phase_ff, mask_phase_in;
   logic [31:0]                          key_store_ff, key_store_in;
   logic                                 in_frame_ff, in_frame_in;

   logic                    emit_valid;
   wsenc_pkg::rsp_beat_type emit_beat;
   logic                    emit_room;
   wsenc_pkg::rsp_beat_type rsp_beat;

   assign req_opcode = req_tdata[3:0];
   assign req_length = req_tdata[35:4];
   assign req_key    = req_tdata[67:36];
   assign req_data   = req_tdata[75:68];

   assign req_tready   = !hdr_active_ff && emit_room;
   assign req_fire     = req_tvalid && req_tready;
   assign hdr_last_idx = wsenc_pkg::hdr_last(form_ff);
   assign pay_fire     = req_fire && in_frame_ff &&
                         (wsenc_pkg::kind_type'(req_tuser) == wsenc_pkg::KIND_DATA);

   always_comb begin
      hdr_active_in = hdr_active_ff;
      hdr_idx_in    = hdr_idx_ff;
      form_in       = form_ff;
      bytes_left_in = bytes_left_ff;
      mask_phase_in = mask_phase_ff;
      key_store_in  = key_store_ff;
      in_frame_in   = in_frame_ff;
      emit_valid    = 1'b0;
      emit_beat     = '0;
      if (hdr_active_ff) begin
         if (emit_room) begin
            emit_valid         = 1'b1;
            emit_beat.out_byte = wsenc_pkg::hdr_byte(form_ff, hdr_idx_ff, bytes_left_ff,
                                                     key_store_ff);
            if (hdr_idx_ff == hdr_last_idx) begin
               emit_beat.frame_end = (bytes_left_ff == 32'd0);
               hdr_active_in       = 1'b0;
            end else begin
               hdr_idx_in = hdr_idx_ff + wsenc_pkg::HDR_IDX_W'(1);
            end
         end
      end else if (req_fire) begin
         if (wsenc_pkg::kind_type'(req_tuser) == wsenc_pkg::KIND_START) begin
            emit_valid         = 1'b1;
            emit_beat.out_byte = wsenc_pkg::FIN_BIT | {4'h0, req_opcode & wsenc_pkg::OPCODE_MSK};
            hdr_active_in      = 1'b1;
            hdr_idx_in         = wsenc_pkg::HDR_IDX_W'(1);
            form_in            = wsenc_pkg::classify(req_length);
            bytes_left_in      = req_length;
            mask_phase_in      = 2'd0;
            key_store_in       = req_key;
            in_frame_in        = (req_length != 32'd0);
         end else if (in_frame_ff) begin
            emit_valid          = 1'b1;
            emit_beat.out_byte  = req_data ^ wsenc_pkg::key_byte(key_store_ff, mask_phase_ff);
            emit_beat.frame_end = (bytes_left_ff == 32'd1);
            bytes_left_in       = bytes_left_ff - 32'd1;
            mask_phase_in       = mask_phase_ff + 2'd1;
            if (bytes_left_ff == 32'd1) begin
               in_frame_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_active_ff <= 1'b0;
         hdr_idx_ff    <= '0;
         form_ff       <= wsenc_pkg::FORM_LEN7;
         bytes_left_ff <= '0;
         mask_phase_ff <= '0;
         key_store_ff  <= '0;
         in_frame_ff   <= 1'b0;
      end else begin
         hdr_active_ff <= hdr_active_in;
         hdr_idx_ff    <= hdr_idx_in;
         form_ff       <= form_in;
         bytes_left_ff <= bytes_left_in;
         mask_phase_ff <= mask_phase_in;
         key_store_ff  <= key_store_in;
         in_frame_ff   <= in_frame_in;
      end
   end

   wsenc_rsp_skid u_rsp_skid (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (emit_valid),
      .beat       (emit_beat),
      .beat_room  (emit_room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_beat   (rsp_beat)
   );

   assign rsp_tdata = rsp_beat.out_byte;
   assign rsp_tlast = rsp_beat.frame_end;

`include "websocket_client_frame_encoder_macros.svh"

   `WSENC_ASSERT(a_hdr_blocks_req, !hdr_active_ff || !req_tready, "request taken during header")
   `WSENC_ASSERT(a_hdr_idx_range, !hdr_active_ff || hdr_idx_ff <= hdr_last_idx, "header overrun")
   `WSENC_ASSERT(a_frame_has_bytes, !in_frame_ff || (bytes_left_ff != 32'd0), "open frame with no bytes left")
   `WSENC_ASSERT(a_phase_step, !pay_fire || mask_phase_in == mask_phase_ff + 2'd1, "phase stuck")

endmodule

`default_nettype wire
